[src/sfa_pkg.sv]
// Shared types, codes and defaults for the spring force accumulator.
package sfa_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_SPRING = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_MUL,
    ST_SQ_WB,
    ST_SQRT,
    ST_CHK,
    ST_DIV,
    ST_SC_MUL,
    ST_SC_WB,
    ST_ST_MUL,
    ST_ST_WB,
    ST_DP_MUL,
    ST_DP_WB,
    ST_AC_MUL,
    ST_AC_WB
  } state_t;

  typedef enum logic [2:0] {
    MOP_SQ,
    MOP_SCALE,
    MOP_ST,
    MOP_DAMP,
    MOP_ACC
  } mop_t;

  typedef struct packed {
    logic load_start;
    logic load_spring;
    logic out_load;
    logic idx_clr;
    logic idx_inc;
    logic mul_en;
    logic wb_en;
    mop_t mop;
    logic sqrt_en;
    logic chk;
    logic div_en;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic idx_last;
    logic cnt_last;
    logic norm_zero;
    logic has_st;
  } sts_t;

endpackage

[src/sfa_datapath.sv]
// Datapath: particle state, shared two-pass multiplier, square root, divider, accumulators.
module sfa_datapath #(
  parameter int DATA_WIDTH = sfa_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = sfa_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sfa_pkg::cmd_t                cmd,
  output sfa_pkg::sts_t                sts,
  input  logic signed [DATA_WIDTH-1:0] pos_x,
  input  logic signed [DATA_WIDTH-1:0] pos_y,
  input  logic signed [DATA_WIDTH-1:0] pos_z,
  input  logic signed [DATA_WIDTH-1:0] vel_x,
  input  logic signed [DATA_WIDTH-1:0] vel_y,
  input  logic signed [DATA_WIDTH-1:0] vel_z,
  input  logic        [DATA_WIDTH-2:0] rest_length,
  input  logic signed [DATA_WIDTH-1:0] stiffness,
  input  logic signed [DATA_WIDTH-1:0] damping,
  input  logic        [DATA_WIDTH-2:0] inv_mass,
  output logic signed [DATA_WIDTH-1:0] accel_x,
  output logic signed [DATA_WIDTH-1:0] accel_y,
  output logic signed [DATA_WIDTH-1:0] accel_z,
  output logic                         degenerate
);
  import sfa_pkg::*;

  localparam int W    = DATA_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int H    = W / 2;
  localparam int HB   = W - H;
  localparam int PW   = W + HB;
  localparam int NB   = W - 1 + F;
  localparam int SW   = 2 * W + 2;
  localparam int CMAX = (NB > W + 1) ? NB : W + 1;
  localparam int CW   = $clog2(CMAX + 1);

  localparam logic [CW-1:0] SQRT_STEPS = CW'(W + 1);
  localparam logic [CW-1:0] DIV_STEPS  = CW'(NB);
  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [2*W-1:0] LIM_N = (2*W)'(1) << (W - 1);
  localparam logic [2*W-1:0] LIM_P = LIM_N - (2*W)'(1);
  localparam logic [W:0]     ONE_FX = (W+1)'(1) << F;

  logic signed [W-1:0] own_pos_r [3];
  logic signed [W-1:0] own_vel_r [3];
  logic signed [W-1:0] acc_r [3];
  logic        [W-2:0] invm_r;
  logic                deg_r;
  logic signed [W:0]   d_r [3];
  logic signed [W:0]   dv_r [3];
  logic signed [W-1:0] k_r, c_r, scale_r, st_r, force_r;
  logic        [W-2:0] len_r;
  logic [SW-1:0]       s_r;
  logic [W+1:0]        rem_r;
  logic [W:0]          root_r;
  logic [NB-1:0]       num_r, q_r;
  logic [CW-1:0]       cnt_r;
  logic [1:0]          idx_r;
  logic                mph_r, neg_r, has_st_r;
  logic [2*W-1:0]      prod_r;
  logic signed [W-1:0] out_x_r, out_y_r, out_z_r;
  logic                out_deg_r;

  logic signed [W-1:0] pos_in [3];
  logic signed [W-1:0] vel_in [3];

  assign pos_in[0] = pos_x;
  assign pos_in[1] = pos_y;
  assign pos_in[2] = pos_z;
  assign vel_in[0] = vel_x;
  assign vel_in[1] = vel_y;
  assign vel_in[2] = vel_z;

  function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) begin
      return s[W] ? SMIN : SMAX;
    end
    return s[W-1:0];
  endfunction

  // Quotient saturates to the largest positive word.
  logic          q_ovf;
  logic [W-2:0]  ratio;
  logic [W:0]    one_minus;

  assign q_ovf     = |q_r[NB-1:W-1];
  assign ratio     = q_ovf ? {(W-1){1'b1}} : q_r[W-2:0];
  assign one_minus = ONE_FX - {2'b00, ratio};

  // Operand selection for the shared multiplier.
  logic signed [W:0] op_a, op_b, a_neg, b_neg;
  logic [W-1:0]      a_mag, b_mag;
  logic [HB-1:0]     b_part;
  logic [PW-1:0]     part;
  logic [2*W-1:0]    prod_nxt;

  always_comb begin
    case (cmd.mop)
      MOP_SQ: begin
        op_a = d_r[idx_r];
        op_b = d_r[idx_r];
      end
      MOP_SCALE: begin
        op_a = one_minus;
        op_b = {k_r[W-1], k_r};
      end
      MOP_ST: begin
        op_a = d_r[idx_r];
        op_b = {scale_r[W-1], scale_r};
      end
      MOP_DAMP: begin
        op_a = dv_r[idx_r];
        op_b = {c_r[W-1], c_r};
      end
      MOP_ACC: begin
        op_a = {force_r[W-1], force_r};
        op_b = {2'b00, invm_r};
      end
      default: begin
        op_a = d_r[idx_r];
        op_b = d_r[idx_r];
      end
    endcase
  end

  assign a_neg  = -op_a;
  assign b_neg  = -op_b;
  assign a_mag  = op_a[W] ? a_neg[W-1:0] : op_a[W-1:0];
  assign b_mag  = op_b[W] ? b_neg[W-1:0] : op_b[W-1:0];
  assign b_part = mph_r ? b_mag[W-1:H] : HB'(b_mag[H-1:0]);
  assign part   = PW'(a_mag) * PW'(b_part);
  assign prod_nxt = mph_r ? prod_r + ((2*W)'(part) << H) : (2*W)'(part);

  // Product scaled back by the fraction bits and saturated to a word.
  logic [2*W-1:0]      psh;
  logic [W-1:0]        psh_neg;
  logic signed [W-1:0] fxr;

  assign psh     = prod_r >> F;
  assign psh_neg = ~psh[W-1:0] + 1'b1;

  always_comb begin
    if (neg_r) begin
      fxr = (psh > LIM_N) ? SMIN : psh_neg;
    end else begin
      fxr = (psh > LIM_P) ? SMAX : psh[W-1:0];
    end
  end

  // One result bit of the square root per step.
  logic [W+3:0] sq_rem2, sq_trial, sq_diff;
  logic         sq_ge;

  assign sq_rem2  = {rem_r, s_r[SW-1:SW-2]};
  assign sq_trial = {1'b0, root_r, 2'b01};
  assign sq_ge    = sq_rem2 >= sq_trial;
  assign sq_diff  = sq_rem2 - sq_trial;

  // One quotient bit of the restoring divider per step.
  logic [W+1:0] dv_rem2, dv_den, dv_diff;
  logic         dv_ge;

  assign dv_rem2 = {rem_r[W:0], num_r[NB-1]};
  assign dv_den  = {1'b0, root_r};
  assign dv_ge   = dv_rem2 >= dv_den;
  assign dv_diff = dv_rem2 - dv_den;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        own_pos_r[i] <= '0;
        own_vel_r[i] <= '0;
        acc_r[i]     <= '0;
      end
      invm_r <= '0;
      deg_r  <= 1'b0;
      mph_r  <= 1'b0;
      idx_r  <= '0;
    end else begin
      if (cmd.load_start) begin
        for (int i = 0; i < 3; i++) begin
          own_pos_r[i] <= pos_in[i];
          own_vel_r[i] <= vel_in[i];
          acc_r[i]     <= '0;
        end
        invm_r <= inv_mass;
        deg_r  <= 1'b0;
      end
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + 2'd1;
      end
      mph_r <= cmd.mul_en ? ~mph_r : 1'b0;
      if (cmd.chk && root_r == '0) begin
        deg_r <= 1'b1;
      end
      if (cmd.wb_en && cmd.mop == MOP_ACC) begin
        acc_r[idx_r] <= sat_add(acc_r[idx_r], fxr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_spring) begin
      for (int i = 0; i < 3; i++) begin
        d_r[i]  <= {pos_in[i][W-1], pos_in[i]} - {own_pos_r[i][W-1], own_pos_r[i]};
        dv_r[i] <= {vel_in[i][W-1], vel_in[i]} - {own_vel_r[i][W-1], own_vel_r[i]};
      end
      k_r   <= stiffness;
      c_r   <= damping;
      len_r <= rest_length;
      s_r   <= '0;
    end
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
      if (!mph_r) begin
        neg_r <= op_a[W] ^ op_b[W];
      end
    end
    if (cmd.wb_en) begin
      case (cmd.mop)
        MOP_SQ: begin
          s_r    <= s_r + SW'(prod_r);
          rem_r  <= '0;
          root_r <= '0;
          cnt_r  <= SQRT_STEPS;
        end
        MOP_SCALE: scale_r <= fxr;
        MOP_ST:    st_r    <= fxr;
        MOP_DAMP:  force_r <= sat_add(st_r, fxr);
        default: ;
      endcase
    end
    if (cmd.sqrt_en) begin
      s_r    <= s_r << 2;
      rem_r  <= sq_ge ? sq_diff[W+1:0] : sq_rem2[W+1:0];
      root_r <= {root_r[W-1:0], sq_ge};
      cnt_r  <= cnt_r - 1'b1;
    end
    if (cmd.chk) begin
      rem_r    <= '0;
      num_r    <= {len_r, {F{1'b0}}};
      cnt_r    <= DIV_STEPS;
      has_st_r <= root_r != '0;
      if (root_r == '0) begin
        st_r <= '0;
      end
    end
    if (cmd.div_en) begin
      rem_r <= dv_ge ? dv_diff : dv_rem2;
      q_r   <= {q_r[NB-2:0], dv_ge};
      num_r <= num_r << 1;
      cnt_r <= cnt_r - 1'b1;
    end
    if (cmd.out_load) begin
      out_x_r   <= acc_r[0];
      out_y_r   <= acc_r[1];
      out_z_r   <= acc_r[2];
      out_deg_r <= deg_r;
    end
  end

  assign sts.mul_done  = cmd.mul_en & mph_r;
  assign sts.idx_last  = idx_r == 2'd2;
  assign sts.cnt_last  = cnt_r == CW'(1);
  assign sts.norm_zero = root_r == '0;
  assign sts.has_st    = has_st_r;

  assign accel_x    = out_x_r;
  assign accel_y    = out_y_r;
  assign accel_z    = out_z_r;
  assign degenerate = out_deg_r;

endmodule

[src/sfa_ctrl.sv]
// Controller state machine that sequences the datapath for each item.
module sfa_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  logic [1:0]      in_op,
  input  logic            in_active,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  output sfa_pkg::cmd_t   cmd,
  input  sfa_pkg::sts_t   sts,
  output sfa_pkg::state_t state
);
  import sfa_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   rdy;

  // Besides waiting for idle, a finish waits only while the previous result is still held.
  assign rdy       = !(in_op == OP_FINISH && out_valid_r && !out_tready);
  assign in_tready = (state_r == ST_IDLE) && rdy;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && rdy && in_op == OP_SPRING && in_active) begin
          state_nxt = ST_SQ_MUL;
        end
      end
      ST_SQ_MUL: if (sts.mul_done) state_nxt = ST_SQ_WB;
      ST_SQ_WB:  state_nxt = sts.idx_last ? ST_SQRT : ST_SQ_MUL;
      ST_SQRT:   if (sts.cnt_last) state_nxt = ST_CHK;
      ST_CHK:    state_nxt = sts.norm_zero ? ST_DP_MUL : ST_DIV;
      ST_DIV:    if (sts.cnt_last) state_nxt = ST_SC_MUL;
      ST_SC_MUL: if (sts.mul_done) state_nxt = ST_SC_WB;
      ST_SC_WB:  state_nxt = ST_ST_MUL;
      ST_ST_MUL: if (sts.mul_done) state_nxt = ST_ST_WB;
      ST_ST_WB:  state_nxt = ST_DP_MUL;
      ST_DP_MUL: if (sts.mul_done) state_nxt = ST_DP_WB;
      ST_DP_WB:  state_nxt = ST_AC_MUL;
      ST_AC_MUL: if (sts.mul_done) state_nxt = ST_AC_WB;
      ST_AC_WB: begin
        if (sts.idx_last) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = sts.has_st ? ST_ST_MUL : ST_DP_MUL;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd     = '0;
    cmd.mop = MOP_SQ;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && rdy) begin
          case (in_op)
            OP_START:  cmd.load_start = 1'b1;
            OP_SPRING: begin
              cmd.load_spring = in_active;
              cmd.idx_clr     = in_active;
            end
            OP_FINISH: cmd.out_load = 1'b1;
            default: ;
          endcase
        end
      end
      ST_SQ_MUL: cmd.mul_en = 1'b1;
      ST_SQ_WB: begin
        cmd.wb_en   = 1'b1;
        cmd.idx_clr = sts.idx_last;
        cmd.idx_inc = !sts.idx_last;
      end
      ST_SQRT: cmd.sqrt_en = 1'b1;
      ST_CHK:  cmd.chk     = 1'b1;
      ST_DIV:  cmd.div_en  = 1'b1;
      ST_SC_MUL: begin
        cmd.mul_en = 1'b1;
        cmd.mop    = MOP_SCALE;
      end
      ST_SC_WB: begin
        cmd.wb_en = 1'b1;
        cmd.mop   = MOP_SCALE;
      end
      ST_ST_MUL: begin
        cmd.mul_en = 1'b1;
        cmd.mop    = MOP_ST;
      end
      ST_ST_WB: begin
        cmd.wb_en = 1'b1;
        cmd.mop   = MOP_ST;
      end
      ST_DP_MUL: begin
        cmd.mul_en = 1'b1;
        cmd.mop    = MOP_DAMP;
      end
      ST_DP_WB: begin
        cmd.wb_en = 1'b1;
        cmd.mop   = MOP_DAMP;
      end
      ST_AC_MUL: begin
        cmd.mul_en = 1'b1;
        cmd.mop    = MOP_ACC;
      end
      ST_AC_WB: begin
        cmd.wb_en   = 1'b1;
        cmd.mop     = MOP_ACC;
        cmd.idx_inc = !sts.idx_last;
      end
      default: ;
    endcase
  end

  assign out_valid_nxt = cmd.out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign state      = state_r;

endmodule

[src/spring_force_accumulator_core.sv]
// Start, finish, inactive spring and unused codes are handled in the idle state; a finish
// shows its result in the register after the transfer. An active spring keeps the block busy
// through the one-bit-per-cycle square root, the restoring divider and thirteen two-pass
// multiplies. A spring whose particles coincide skips the divider, scale and stretch multiplies
// and is flagged degenerate. No new item is taken until the block is back in idle.
// Reset clears all particle state and accumulators to zero.
module spring_force_accumulator_core #(
  parameter int  DATA_WIDTH = sfa_pkg::DATA_WIDTH_DEF,
  parameter int  FRAC_BITS  = sfa_pkg::FRAC_BITS_DEF,
  localparam int IN_W  = ((10 * DATA_WIDTH - 1 + 7) / 8) * 8,
  localparam int OUT_W = ((3 * DATA_WIDTH + 1 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, rest_length, stiffness, damping,
  // spring_active, inv_mass
  input  logic [IN_W-1:0]  in_tdata,
  // operation
  input  logic [1:0]       in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  // accel_x, accel_y, accel_z, degenerate
  output logic [OUT_W-1:0] out_tdata
);
  import sfa_pkg::*;

  localparam int W = DATA_WIDTH;

  cmd_t   cmd;
  sts_t   sts;
  state_t state;

  logic signed [W-1:0] accel_x, accel_y, accel_z;
  logic                degenerate;
  logic                spring_active;

  assign spring_active = in_tdata[9*W-1];

  sfa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_op      (in_tuser),
    .in_active  (spring_active),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts),
    .state      (state)
  );

  sfa_datapath #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .pos_x       (in_tdata[W-1:0]),
    .pos_y       (in_tdata[2*W-1:W]),
    .pos_z       (in_tdata[3*W-1:2*W]),
    .vel_x       (in_tdata[4*W-1:3*W]),
    .vel_y       (in_tdata[5*W-1:4*W]),
    .vel_z       (in_tdata[6*W-1:5*W]),
    .rest_length (in_tdata[7*W-2:6*W]),
    .stiffness   (in_tdata[8*W-2:7*W-1]),
    .damping     (in_tdata[9*W-2:8*W-1]),
    .inv_mass    (in_tdata[10*W-2:9*W]),
    .accel_x     (accel_x),
    .accel_y     (accel_y),
    .accel_z     (accel_z),
    .degenerate  (degenerate)
  );

  assign out_tdata = OUT_W'({degenerate, accel_z, accel_y, accel_x});

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state != ST_IDLE) |-> !in_tready)
    else $error("input taken while a spring is in progress");

  a_finish_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == OP_FINISH) |=> out_tvalid)
    else $error("finish transfer produced no result");

  a_spring_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == OP_SPRING && spring_active) |=>
    (state == ST_SQ_MUL))
    else $error("active spring did not start the sequence");

  a_mul_two_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mul_en && !sts.mul_done) |=> (cmd.mul_en && sts.mul_done))
    else $error("multiply did not finish on its second pass");

endmodule
